### rtl/gtl_pkg.sv
package gtl_pkg;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] char_code;
        logic [7:0]  glyph_width;
        logic [7:0]  glyph_height;
        logic [7:0]  glyph_baseline;
        logic [7:0]  package_id;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  slot;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [6:0]  row_number;
        logic [15:0] row_start;
        logic [15:0] row_end;
        logic [15:0] row_width;
        logic [7:0]  row_height;
        logic [7:0]  row_baseline;
        logic [1:0]  status;
        logic [15:0] column;
    } t_out_item;

    typedef struct packed {
        logic [15:0] origin_x;
        logic [15:0] origin_y;
        logic [15:0] canvas_width;
        logic [15:0] canvas_height;
        logic [6:0]  layout_flags;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  pkg;
        logic [15:0] code;
        logic [7:0]  w;
        logic [7:0]  h;
        logic [7:0]  base;
    } t_glyph_entry;

    // Input actions.
    localparam logic [1:0] ACT_REGISTER = 2'd0;
    localparam logic [1:0] ACT_REMOVE   = 2'd1;
    localparam logic [1:0] ACT_CHAR     = 2'd2;
    localparam logic [1:0] ACT_END      = 2'd3;

    // Result kinds.
    localparam logic [2:0] KIND_DRAW   = 3'd0;
    localparam logic [2:0] KIND_ROW    = 3'd1;
    localparam logic [2:0] KIND_TABLE  = 3'd2;
    localparam logic [2:0] KIND_DONE   = 3'd3;
    localparam logic [2:0] KIND_ERROR  = 3'd4;

    // Status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_NO_ROOM  = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    // Flag bit positions.
    localparam int FL_CLIP           = 0;
    localparam int FL_WRAP           = 1;
    localparam int FL_IGNORE_MISSING = 5;
    localparam int FL_IGNORE_NEWLINE = 6;

    localparam logic [15:0] NEWLINE_CODE = 16'd10;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_ORIGIN_X      = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y      = 3'd1;
    localparam logic [2:0] REG_CANVAS_WIDTH  = 3'd2;
    localparam logic [2:0] REG_CANVAS_HEIGHT = 3'd3;
    localparam logic [2:0] REG_LAYOUT_FLAGS  = 3'd4;

    // Job classes decided by the front end.
    typedef enum logic [2:0] {
        OP_REG     = 3'd0,
        OP_BAD     = 3'd1,
        OP_REMOVE  = 3'd2,
        OP_CHAR    = 3'd3,
        OP_NEWLINE = 3'd4,
        OP_END     = 3'd5
    } t_op;

    typedef struct packed {
        t_op      op;
        t_in_item item;
    } t_job;

endpackage

### rtl/gtl_front.sv
module gtl_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  gtl_pkg::t_in_item i_in_item,
    input  logic [6:0]        i_layout_flags,
    output logic              o_job_valid,
    output gtl_pkg::t_job     o_job,
    input  logic              i_pop
);
    import gtl_pkg::*;

    t_job       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt, n_cnt;
    t_job       w_job;
    logic       w_push, w_pop;

    // Classify the item as it enters the queue.
    always_comb begin
        w_job.item = i_in_item;
        case (i_in_item.action)
            ACT_REGISTER: begin
                if (i_in_item.char_code == 16'd0 || i_in_item.glyph_width == 8'd0 ||
                    i_in_item.glyph_height == 8'd0 ||
                    i_in_item.glyph_baseline > i_in_item.glyph_height) begin
                    w_job.op = OP_BAD;
                end else begin
                    w_job.op = OP_REG;
                end
            end
            ACT_REMOVE: w_job.op = OP_REMOVE;
            ACT_CHAR: begin
                if (i_in_item.char_code == NEWLINE_CODE && !i_layout_flags[FL_IGNORE_NEWLINE]) begin
                    w_job.op = OP_NEWLINE;
                end else begin
                    w_job.op = OP_CHAR;
                end
            end
            default: w_job.op = OP_END;
        endcase
    end

    assign o_in_stall  = (r_cnt == 2'd2);
    assign w_push      = i_in_valid && !o_in_stall;
    assign o_job_valid = (r_cnt != 2'd0);
    assign w_pop       = i_pop && o_job_valid;
    assign o_job       = r_q[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!w_push && w_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_job;
        end
    end

endmodule

### rtl/gtl_engine.sv
module gtl_engine #(
    parameter int MAX_GLYPHS = 256,
    parameter int MAX_ROWS   = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gtl_pkg::t_cfg      i_cfg,
    input  logic               i_oy_load,
    input  logic [15:0]        i_oy_value,
    input  logic               i_job_valid,
    input  gtl_pkg::t_job      i_job,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output gtl_pkg::t_out_item o_out_item
);
    import gtl_pkg::*;

    localparam int AW = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
    localparam int CW = $clog2(MAX_GLYPHS + 1);
    localparam int RW = $clog2(MAX_ROWS + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_EXEC = 5'b00100,
        S_DRAW = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    t_job               r_job, n_job;
    t_glyph_entry       r_mem [MAX_GLYPHS];
    logic [MAX_GLYPHS-1:0] r_valid;
    t_glyph_entry       r_rd_data;
    logic               r_rd_vbit, r_rd_pend;
    logic [AW-1:0]      r_rd_idx;
    logic [CW-1:0]      r_scan_cnt;
    logic               r_hit, r_free;
    logic [AW-1:0]      r_hit_idx, r_free_idx;
    logic [7:0]         r_hit_w, r_hit_h, r_hit_b;

    logic [15:0]        r_off_x, n_off_x, r_pos_y, n_pos_y;
    logic [7:0]         r_lh, n_lh, r_lb, n_lb;
    logic [15:0]        r_row_first, n_row_first, r_char_idx, n_char_idx;
    logic [RW-1:0]      r_rows, n_rows;
    logic               r_aborted, n_aborted;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;

    logic               w_out_free, w_scan_start, w_scan_done, w_scan_issue;
    logic               w_mem_we, w_row_ok, w_x_over, w_y_over, w_remove_hit;
    logic [AW-1:0]      w_mem_idx;
    logic [17:0]        w_x_end;
    logic [16:0]        w_y_end;
    t_glyph_entry       w_entry;

    assign w_out_free   = !r_out_valid || !i_out_stall;
    assign w_scan_issue = (r_state == S_SCAN) && (r_scan_cnt < CW'(MAX_GLYPHS));
    assign w_scan_done  = (r_state == S_SCAN) && !w_scan_issue && !r_rd_pend;
    assign w_row_ok     = (r_rows < RW'(MAX_ROWS));
    assign w_x_end      = {2'b0, i_cfg.origin_x} + {2'b0, r_off_x} + {10'b0, r_hit_w};
    assign w_x_over     = w_x_end > {2'b0, i_cfg.canvas_width};
    assign w_y_end      = {1'b0, r_pos_y} + {9'b0, r_hit_h};
    assign w_y_over     = w_y_end > {1'b0, i_cfg.canvas_height};
    assign w_mem_idx    = r_hit ? r_hit_idx : r_free_idx;
    assign w_remove_hit = r_rd_pend && (r_job.op == OP_REMOVE) && r_rd_vbit &&
                          (r_rd_data.pkg == r_job.item.package_id);

    assign w_entry.pkg  = r_job.item.package_id;
    assign w_entry.code = r_job.item.char_code;
    assign w_entry.w    = r_job.item.glyph_width;
    assign w_entry.h    = r_job.item.glyph_height;
    assign w_entry.base = r_job.item.glyph_baseline;

    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_off_x     = r_off_x;
        n_pos_y     = r_pos_y;
        n_lh        = r_lh;
        n_lb        = r_lb;
        n_row_first = r_row_first;
        n_char_idx  = r_char_idx;
        n_rows      = r_rows;
        n_aborted   = r_aborted;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        o_pop        = 1'b0;
        w_scan_start = 1'b0;
        w_mem_we     = 1'b0;

        if (i_oy_load && r_char_idx == 16'd0 && !r_aborted) begin
            n_pos_y = i_oy_value;
        end

        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    o_pop = 1'b1;
                    n_job = i_job;
                    case (i_job.op)
                        OP_CHAR: begin
                            if (!r_aborted) begin
                                w_scan_start = 1'b1;
                                n_state      = S_SCAN;
                            end
                        end
                        OP_NEWLINE: begin
                            if (!r_aborted) begin
                                n_state = S_EXEC;
                            end
                        end
                        OP_REG, OP_REMOVE: begin
                            w_scan_start = 1'b1;
                            n_state      = S_SCAN;
                        end
                        default: n_state = S_EXEC;
                    endcase
                end
            end
            S_SCAN: begin
                if (w_scan_done) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_out_free) begin
                    n_out       = '0;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    // A row close needs its record or the overflow error.
                    if (w_row_ok) begin
                        n_out.kind         = KIND_ROW;
                        n_out.row_number   = 7'(r_rows);
                        n_out.row_start    = r_row_first;
                        n_out.row_end      = r_char_idx;
                        n_out.row_width    = r_off_x;
                        n_out.row_height   = r_lh;
                        n_out.row_baseline = r_lb;
                    end else begin
                        n_out.kind   = KIND_ERROR;
                        n_out.status = ST_NO_ROOM;
                        n_out.column = r_char_idx;
                    end
                    case (r_job.op)
                        OP_BAD: begin
                            n_out        = '0;
                            n_out.kind   = KIND_TABLE;
                            n_out.status = ST_INVALID;
                        end
                        OP_REG: begin
                            n_out      = '0;
                            n_out.kind = KIND_TABLE;
                            if (r_hit || r_free) begin
                                w_mem_we   = 1'b1;
                                n_out.slot = 8'(w_mem_idx);
                            end else begin
                                n_out.status = ST_NO_ROOM;
                            end
                        end
                        OP_REMOVE: begin
                            n_out      = '0;
                            n_out.kind = KIND_TABLE;
                        end
                        OP_END: begin
                            if (r_aborted) begin
                                n_out_valid = r_out_valid && i_out_stall;
                            end
                            if (!r_aborted && w_row_ok) begin
                                n_rows  = r_rows + RW'(1);
                                n_state = S_DONE;
                            end else begin
                                n_off_x     = '0;
                                n_pos_y     = i_cfg.origin_y;
                                n_lh        = '0;
                                n_lb        = '0;
                                n_row_first = '0;
                                n_char_idx  = '0;
                                n_rows      = '0;
                                n_aborted   = 1'b0;
                            end
                        end
                        OP_NEWLINE: begin
                            if (w_row_ok) begin
                                n_rows      = r_rows + RW'(1);
                                n_pos_y     = r_pos_y + {8'b0, r_lh};
                                n_off_x     = '0;
                                n_lh        = '0;
                                n_lb        = '0;
                                n_char_idx  = r_char_idx + 16'd1;
                                n_row_first = r_char_idx + 16'd1;
                            end else begin
                                n_aborted = 1'b1;
                            end
                        end
                        default: begin
                            if (!r_hit) begin
                                if (!i_cfg.layout_flags[FL_IGNORE_MISSING]) begin
                                    n_out        = '0;
                                    n_out.kind   = KIND_ERROR;
                                    n_out.status = ST_NOTFOUND;
                                    n_out.column = r_char_idx;
                                    n_aborted    = 1'b1;
                                end else begin
                                    n_out_valid = r_out_valid && i_out_stall;
                                    n_char_idx  = r_char_idx + 16'd1;
                                end
                            end else if (i_cfg.layout_flags[FL_WRAP] && r_off_x != 16'd0 &&
                                         w_x_over) begin
                                if (w_row_ok) begin
                                    n_rows      = r_rows + RW'(1);
                                    n_pos_y     = r_pos_y + {8'b0, r_lh};
                                    n_off_x     = '0;
                                    n_lh        = '0;
                                    n_lb        = '0;
                                    n_row_first = r_char_idx;
                                    n_state     = S_DRAW;
                                end else begin
                                    n_aborted = 1'b1;
                                end
                            end else begin
                                n_out_valid = r_out_valid && i_out_stall;
                                n_state     = S_DRAW;
                            end
                        end
                    endcase
                end
            end
            S_DRAW: begin
                if (i_cfg.layout_flags[FL_CLIP] && (w_x_over || w_y_over)) begin
                    n_char_idx = r_char_idx + 16'd1;
                    n_state    = S_IDLE;
                end else if (w_out_free) begin
                    n_out       = '0;
                    n_out.kind  = KIND_DRAW;
                    n_out.slot  = 8'(r_hit_idx);
                    n_out.pos_x = i_cfg.origin_x + r_off_x;
                    n_out.pos_y = r_pos_y;
                    n_out_valid = 1'b1;
                    n_off_x     = r_off_x + {8'b0, r_hit_w};
                    n_lh        = (r_hit_h > r_lh) ? r_hit_h : r_lh;
                    n_lb        = (r_hit_b > r_lb) ? r_hit_b : r_lb;
                    n_char_idx  = r_char_idx + 16'd1;
                    n_state     = S_IDLE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out        = '0;
                    n_out.kind   = KIND_DONE;
                    n_out.column = r_char_idx;
                    n_out_valid  = 1'b1;
                    n_off_x      = '0;
                    n_pos_y      = i_cfg.origin_y;
                    n_lh         = '0;
                    n_lb         = '0;
                    n_row_first  = '0;
                    n_char_idx   = '0;
                    n_rows       = '0;
                    n_aborted    = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_off_x     <= '0;
            r_pos_y     <= '0;
            r_lh        <= '0;
            r_lb        <= '0;
            r_row_first <= '0;
            r_char_idx  <= '0;
            r_rows      <= '0;
            r_aborted   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_off_x     <= n_off_x;
            r_pos_y     <= n_pos_y;
            r_lh        <= n_lh;
            r_lb        <= n_lb;
            r_row_first <= n_row_first;
            r_char_idx  <= n_char_idx;
            r_rows      <= n_rows;
            r_aborted   <= n_aborted;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        r_out <= n_out;
    end

    // Scan pipeline: one table read issued per cycle, compared in the next cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_cnt <= '0;
            r_rd_pend  <= 1'b0;
            r_hit      <= 1'b0;
            r_free     <= 1'b0;
        end else if (w_scan_start) begin
            r_scan_cnt <= '0;
            r_rd_pend  <= 1'b0;
            r_hit      <= 1'b0;
            r_free     <= 1'b0;
        end else begin
            r_rd_pend <= w_scan_issue;
            if (w_scan_issue) begin
                r_scan_cnt <= r_scan_cnt + CW'(1);
            end
            if (r_rd_pend && r_rd_vbit && r_rd_data.code == r_job.item.char_code) begin
                r_hit <= 1'b1;
            end
            if (r_rd_pend && !r_rd_vbit && !r_free) begin
                r_free <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_scan_issue) begin
            r_rd_idx  <= r_scan_cnt[AW-1:0];
            r_rd_vbit <= r_valid[r_scan_cnt[AW-1:0]];
        end
        if (r_rd_pend && r_rd_vbit && r_rd_data.code == r_job.item.char_code) begin
            r_hit_idx <= r_rd_idx;
            r_hit_w   <= r_rd_data.w;
            r_hit_h   <= r_rd_data.h;
            r_hit_b   <= r_rd_data.base;
        end
        if (r_rd_pend && !r_rd_vbit && !r_free) begin
            r_free_idx <= r_rd_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_idx] <= w_entry;
        end
        r_rd_data <= r_mem[r_scan_cnt[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_remove_hit) begin
                r_valid[r_rd_idx] <= 1'b0;
            end
            if (w_mem_we) begin
                r_valid[w_mem_idx] <= 1'b1;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef SYNTH
    a_rows_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rows <= RW'(MAX_ROWS))
        else $error("row count above limit");
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan_cnt <= CW'(MAX_GLYPHS))
        else $error("scan counter past table end");
    a_draw_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAW) |-> !r_aborted)
        else $error("draw step on aborted string");
    a_write_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |=> r_valid[$past(w_mem_idx)])
        else $error("written slot not marked valid");
`endif

endmodule

### rtl/glyph_text_layout_engine.sv
// Glyph text layout engine. Keeps a table of MAX_GLYPHS glyph metric entries
// and lays out a character stream into draw commands and row records. Items
// enter a two-deep queue where they are classified, and an execution engine
// behind the queue carries them out, so the input keeps taking transactions
// until the queue is full while a result waits at the output register.
// Register and remove items and every non-newline character of a live string
// scan all entries of the glyph memory in turn through its single read port,
// one entry per cycle. Characters of an aborted string are dropped without a
// scan. Invalid register items, newlines and end-of-string skip the scan. An
// end-of-string item of a live string gives a row record and then a done
// record, or the overflow error at the row limit; on an aborted string it
// gives none. Output stalls hold any item that has a result to give. Valid
// bits of the table are cleared at reset, so no clearing pass is needed. The
// user must write configuration through the APB-style port only while the
// block is idle; the block itself does not enforce this.
module glyph_text_layout_engine #(
    parameter int MAX_GLYPHS = 256,
    parameter int MAX_ROWS   = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  gtl_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output gtl_pkg::t_out_item o_out_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import gtl_pkg::*;

    t_cfg  r_cfg;
    logic  w_wr;
    logic  w_oy_load;
    logic  w_job_valid;
    logic  w_pop;
    t_job  w_job;

    // A write completes in the access cycle; pready is tied high.
    assign pready    = 1'b1;
    assign w_wr      = psel && penable && pwrite;
    assign w_oy_load = w_wr && (paddr[4:2] == REG_ORIGIN_Y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x      <= 16'd0;
            r_cfg.origin_y      <= 16'd0;
            r_cfg.canvas_width  <= 16'd640;
            r_cfg.canvas_height <= 16'd480;
            r_cfg.layout_flags  <= 7'd0;
        end else if (w_wr) begin
            case (paddr[4:2])
                REG_ORIGIN_X:      r_cfg.origin_x      <= pwdata[15:0];
                REG_ORIGIN_Y:      r_cfg.origin_y      <= pwdata[15:0];
                REG_CANVAS_WIDTH:  r_cfg.canvas_width  <= pwdata[15:0];
                REG_CANVAS_HEIGHT: r_cfg.canvas_height <= pwdata[15:0];
                REG_LAYOUT_FLAGS:  r_cfg.layout_flags  <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (paddr[4:2])
            REG_ORIGIN_X:      prdata = {16'd0, r_cfg.origin_x};
            REG_ORIGIN_Y:      prdata = {16'd0, r_cfg.origin_y};
            REG_CANVAS_WIDTH:  prdata = {16'd0, r_cfg.canvas_width};
            REG_CANVAS_HEIGHT: prdata = {16'd0, r_cfg.canvas_height};
            REG_LAYOUT_FLAGS:  prdata = {25'd0, r_cfg.layout_flags};
            default:           prdata = 32'd0;
        endcase
    end

    // Front end: input queue and action classification.
    gtl_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_in_item      (i_in_item),
        .i_layout_flags (r_cfg.layout_flags),
        .o_job_valid    (w_job_valid),
        .o_job          (w_job),
        .i_pop          (w_pop)
    );

    // Back end: table scan, layout state and the output register.
    gtl_engine #(
        .MAX_GLYPHS (MAX_GLYPHS),
        .MAX_ROWS   (MAX_ROWS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_oy_load   (w_oy_load),
        .i_oy_value  (pwdata[15:0]),
        .i_job_valid (w_job_valid),
        .i_job       (w_job),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

### verif/glyph_text_layout_engine_checker.sv
`timescale 1ns / 100ps

module glyph_text_layout_engine_checker
    import gtl_pkg::*;
#(
    parameter int MAX_GLYPHS = 256,
    parameter int MAX_ROWS   = 128
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_item,
    input  logic      i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [15:0] i_cfg_val,
    output int        o_fail_count,
    output int        o_pending
);

    // Shadow copy of the glyph table and of the layout state.
    logic         shadow_valid [MAX_GLYPHS];
    t_glyph_entry shadow_glyph [MAX_GLYPHS];
    t_cfg         shadow_cfg;
    logic [15:0]  lay_x, lay_y, row_first, char_idx;
    logic [7:0]   lay_h, lay_b;
    int           rows_done;
    logic         lay_aborted;

    t_out_item expected_results[$];

    function automatic t_out_item blank(input logic [2:0] kind);
        t_out_item r;
        r = '0;
        r.kind = kind;
        return r;
    endfunction

    task automatic restart_layout();
        lay_x = '0;
        lay_y = shadow_cfg.origin_y;
        lay_h = '0;
        lay_b = '0;
        row_first = '0;
        char_idx = '0;
        rows_done = 0;
        lay_aborted = 1'b0;
    endtask

    function automatic void raise_error(input logic [1:0] st);
        t_out_item r;
        r = blank(KIND_ERROR);
        r.status = st;
        r.column = char_idx;
        expected_results.push_back(r);
        lay_aborted = 1'b1;
    endfunction

    // Closes the current row; returns 0 when the row limit aborts the string.
    function automatic bit close_row();
        t_out_item r;
        if (rows_done >= MAX_ROWS) begin
            raise_error(ST_NO_ROOM);
            return 0;
        end
        r = blank(KIND_ROW);
        r.row_number = rows_done[6:0];
        r.row_start = row_first;
        r.row_end = char_idx;
        r.row_width = lay_x;
        r.row_height = lay_h;
        r.row_baseline = lay_b;
        expected_results.push_back(r);
        rows_done++;
        lay_y = lay_y + lay_h;
        lay_x = '0;
        lay_h = '0;
        lay_b = '0;
        return 1;
    endfunction

    function automatic int lookup(input logic [15:0] code);
        for (int i = 0; i < MAX_GLYPHS; i++)
            if (shadow_valid[i] && shadow_glyph[i].code == code) return i;
        return -1;
    endfunction

    task automatic predict_layout(input t_in_item it);
        t_out_item r;
        int s;
        int unsigned right_edge;
        if (it.action == ACT_REGISTER) begin
            r = blank(KIND_TABLE);
            if (it.char_code == 0 || it.glyph_width == 0 || it.glyph_height == 0 ||
                it.glyph_baseline > it.glyph_height) begin
                r.status = ST_INVALID;
            end else begin
                s = lookup(it.char_code);
                if (s < 0)
                    for (int i = 0; i < MAX_GLYPHS; i++)
                        if (!shadow_valid[i]) begin
                            s = i;
                            break;
                        end
                if (s < 0) begin
                    r.status = ST_NO_ROOM;
                end else begin
                    shadow_valid[s] = 1'b1;
                    shadow_glyph[s] = '{pkg: it.package_id, code: it.char_code,
                        w: it.glyph_width, h: it.glyph_height, base: it.glyph_baseline};
                    r.slot = s[7:0];
                end
            end
            expected_results.push_back(r);
        end else if (it.action == ACT_REMOVE) begin
            for (int i = 0; i < MAX_GLYPHS; i++)
                if (shadow_valid[i] && shadow_glyph[i].pkg == it.package_id)
                    shadow_valid[i] = 1'b0;
            expected_results.push_back(blank(KIND_TABLE));
        end else if (it.action == ACT_END) begin
            if (!lay_aborted && close_row()) begin
                r = blank(KIND_DONE);
                r.column = char_idx;
                expected_results.push_back(r);
            end
            restart_layout();
        end else if (!lay_aborted) begin
            if (it.char_code == NEWLINE_CODE && !shadow_cfg.layout_flags[FL_IGNORE_NEWLINE]) begin
                if (close_row()) begin
                    char_idx++;
                    row_first = char_idx;
                end
                return;
            end
            s = lookup(it.char_code);
            if (s < 0) begin
                if (!shadow_cfg.layout_flags[FL_IGNORE_MISSING]) raise_error(ST_NOTFOUND);
                else char_idx++;
                return;
            end
            right_edge = shadow_cfg.origin_x + lay_x + shadow_glyph[s].w;
            if (shadow_cfg.layout_flags[FL_WRAP] && lay_x != 0 &&
                right_edge > shadow_cfg.canvas_width) begin
                if (!close_row()) return;
                row_first = char_idx;
                right_edge = shadow_cfg.origin_x + shadow_glyph[s].w;
            end
            if (shadow_cfg.layout_flags[FL_CLIP] && (right_edge > shadow_cfg.canvas_width ||
                32'(lay_y) + shadow_glyph[s].h > shadow_cfg.canvas_height)) begin
                char_idx++;
                return;
            end
            r = blank(KIND_DRAW);
            r.slot = s[7:0];
            r.pos_x = shadow_cfg.origin_x + lay_x;
            r.pos_y = lay_y;
            expected_results.push_back(r);
            lay_x = lay_x + shadow_glyph[s].w;
            if (shadow_glyph[s].h > lay_h) lay_h = shadow_glyph[s].h;
            if (shadow_glyph[s].base > lay_b) lay_b = shadow_glyph[s].base;
            char_idx++;
        end
    endtask

    task automatic report_mismatch(input string what, input t_out_item got,
                                   input t_out_item want);
        $display("ERROR %0t: %s got %h expected %h", $realtime, what, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_GLYPHS; i++) shadow_valid[i] = 1'b0;
            shadow_cfg = '{origin_x: 16'd0, origin_y: 16'd0, canvas_width: 16'd640,
                           canvas_height: 16'd480, layout_flags: 7'd0};
            restart_layout();
            expected_results.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ORIGIN_X: shadow_cfg.origin_x = i_cfg_val;
                    REG_ORIGIN_Y: begin
                        shadow_cfg.origin_y = i_cfg_val;
                        if (char_idx == 0 && !lay_aborted) lay_y = i_cfg_val;
                    end
                    REG_CANVAS_WIDTH: shadow_cfg.canvas_width = i_cfg_val;
                    REG_CANVAS_HEIGHT: shadow_cfg.canvas_height = i_cfg_val;
                    REG_LAYOUT_FLAGS: shadow_cfg.layout_flags = i_cfg_val[6:0];
                    default: ;
                endcase
            end
            // Results of the same edge are compared before new predictions land.
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected transaction", i_out_item, '0);
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_item.kind !== want.kind) report_mismatch("kind", i_out_item, want);
                    else if (i_out_item.slot !== want.slot) report_mismatch("slot", i_out_item, want);
                    else if (i_out_item.pos_x !== want.pos_x) report_mismatch("pos_x", i_out_item, want);
                    else if (i_out_item.pos_y !== want.pos_y) report_mismatch("pos_y", i_out_item, want);
                    else if (i_out_item.row_number !== want.row_number)
                        report_mismatch("row_number", i_out_item, want);
                    else if (i_out_item.row_start !== want.row_start)
                        report_mismatch("row_start", i_out_item, want);
                    else if (i_out_item.row_end !== want.row_end)
                        report_mismatch("row_end", i_out_item, want);
                    else if (i_out_item.row_width !== want.row_width)
                        report_mismatch("row_width", i_out_item, want);
                    else if (i_out_item.row_height !== want.row_height)
                        report_mismatch("row_height", i_out_item, want);
                    else if (i_out_item.row_baseline !== want.row_baseline)
                        report_mismatch("row_baseline", i_out_item, want);
                    else if (i_out_item.status !== want.status)
                        report_mismatch("status", i_out_item, want);
                    else if (i_out_item.column !== want.column)
                        report_mismatch("column", i_out_item, want);
                end
            end
            if (i_in_valid && !i_in_stall) predict_layout(i_in_item);
        end
        o_pending = expected_results.size();
    end

endmodule

### verif/glyph_text_layout_engine_tb.sv
`timescale 1ns / 100ps

// Top of the layout engine bench. It drives glyph table maintenance and
// character streams into the block, writes the configuration registers
// between phases, and lets the checker beside the block predict and compare
// every result transaction. The top only makes stimulus and gives the verdict.
module glyph_text_layout_engine_tb;
    import gtl_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    // A scan item reads every one of the MAX_GLYPHS table entries; this drain
    // covers a character that may still be at work after the last expected result.
    localparam int DRAIN_CYCLES = 600;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    t_in_item    in_item = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_item   out_item;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int  fail_count, pending;
    int  cycle_count = 0;
    // The receiver reads these to decide how it stalls.
    bit  calm_phase = 1'b0;
    bit  hold_request = 1'b0;
    // Character codes currently registered by the stimulus, for well-formed text.
    logic [15:0] known_codes[$];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    glyph_text_layout_engine DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_item(in_item),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_item(out_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // The checker sees a register write at the access edge, as the block does.
    glyph_text_layout_engine_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_item(in_item),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_item(out_item),
        .i_cfg_we(psel && penable && pwrite && pready),
        .i_cfg_idx(paddr[4:2]), .i_cfg_val(pwdata[15:0]),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("FAIL glyph_text_layout_engine");
            $finish;
        end
    end

    // Receiver: random stall bursts, one long hold on request, none when calm.
    initial begin
        int n;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_request) begin
                out_stall <= 1'b1;
                repeat (3000) @(posedge i_clk);
                hold_request = 1'b0;
            end else if (!calm_phase && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 9);
                out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end else begin
                out_stall <= 1'b0;
                @(posedge i_clk);
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {16'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Waits until every result has come, then lets a scan item finish.
    task automatic settle();
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic send(input t_in_item it);
        int gap;
        if (!calm_phase && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 9);
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
    endtask

    task automatic finish_send();
        in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_in_item make_item(input logic [1:0] act, input logic [15:0] code,
                                           input logic [7:0] w, input logic [7:0] h,
                                           input logic [7:0] b, input logic [7:0] pkg);
        t_in_item it;
        it.action = act;
        it.char_code = code;
        it.glyph_width = w;
        it.glyph_height = h;
        it.glyph_baseline = b;
        it.package_id = pkg;
        return it;
    endfunction

    function automatic t_in_item glyph_char(input logic [15:0] code);
        return make_item(ACT_CHAR, code, 8'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom));
    endfunction

    task automatic register_glyph(input logic [15:0] code, input logic [7:0] pkg);
        logic [7:0] h;
        h = 8'($urandom_range(1, 40));
        send(make_item(ACT_REGISTER, code, 8'($urandom_range(1, 60)), h,
                       8'($urandom_range(0, h)), pkg));
        known_codes.push_back(code);
    endtask

    // A mostly well-formed string of known glyphs, with newlines and a little
    // noise, closed by an end-of-string item.
    task automatic send_string(input int length);
        int pick;
        logic [15:0] code;
        for (int i = 0; i < length; i++) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) code = NEWLINE_CODE;
            else if (pick == 1 || known_codes.size() == 0) code = 16'($urandom);
            else code = known_codes[$urandom_range(0, known_codes.size() - 1)];
            send(glyph_char(code));
        end
        send(make_item(ACT_END, 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                       8'($urandom)));
    endtask

    initial begin
        t_in_item it;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: invalid registrations, extremes, every action.
        send(make_item(ACT_REGISTER, 16'd0, 8'd5, 8'd5, 8'd1, 8'd0));
        send(make_item(ACT_REGISTER, 16'd65, 8'd0, 8'd5, 8'd1, 8'd0));
        send(make_item(ACT_REGISTER, 16'd65, 8'd5, 8'd0, 8'd0, 8'd0));
        send(make_item(ACT_REGISTER, 16'd65, 8'd5, 8'd5, 8'd6, 8'd0));
        send(make_item(ACT_REGISTER, 16'd65, 8'd255, 8'd255, 8'd255, 8'd255));
        send(make_item(ACT_REGISTER, 16'hFFFF, 8'd1, 8'd1, 8'd0, 8'd1));
        send(make_item(ACT_REGISTER, 16'd66, 8'd200, 8'd10, 8'd3, 8'd2));
        send(make_item(ACT_REGISTER, 16'd65, 8'd8, 8'd12, 8'd9, 8'd1));
        known_codes.push_back(16'd65);
        known_codes.push_back(16'hFFFF);
        known_codes.push_back(16'd66);
        send(glyph_char(16'd65));
        send(glyph_char(16'd66));
        send(glyph_char(NEWLINE_CODE));
        send(glyph_char(16'hFFFF));
        send(glyph_char(16'd67));
        send(glyph_char(16'd65));
        send(make_item(ACT_END, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        send(make_item(ACT_END, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send(make_item(ACT_REMOVE, 16'd0, 8'd0, 8'd0, 8'd0, 8'd2));
        send(glyph_char(16'd66));
        send(make_item(ACT_END, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        known_codes.delete(2);
        finish_send();
        settle();

        // Phase settings: wrap, clip, ignore flags and the register extremes.
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin
                    write_reg(REG_LAYOUT_FLAGS, 16'h007F);
                    write_reg(REG_CANVAS_WIDTH, 16'd100);
                    write_reg(REG_CANVAS_HEIGHT, 16'd60);
                end
                1: begin
                    write_reg(REG_LAYOUT_FLAGS, 16'h0022);
                    write_reg(REG_ORIGIN_X, 16'd20);
                    write_reg(REG_ORIGIN_Y, 16'd5);
                end
                2: begin
                    write_reg(REG_ORIGIN_X, 16'hFFFF);
                    write_reg(REG_ORIGIN_Y, 16'hFFF0);
                    write_reg(REG_CANVAS_WIDTH, 16'hFFFF);
                    write_reg(REG_CANVAS_HEIGHT, 16'hFFFF);
                    write_reg(REG_LAYOUT_FLAGS, 16'h0000);
                end
                3: begin
                    write_reg(REG_ORIGIN_X, 16'd0);
                    write_reg(REG_ORIGIN_Y, 16'd0);
                    write_reg(REG_CANVAS_WIDTH, 16'd1);
                    write_reg(REG_CANVAS_HEIGHT, 16'd1);
                    write_reg(REG_LAYOUT_FLAGS, 16'h0023);
                end
                default: begin
                    write_reg(REG_ORIGIN_X, 16'($urandom_range(0, 50)));
                    write_reg(REG_ORIGIN_Y, 16'($urandom_range(0, 50)));
                    write_reg(REG_CANVAS_WIDTH, 16'($urandom_range(60, 400)));
                    write_reg(REG_CANVAS_HEIGHT, 16'($urandom_range(40, 300)));
                    write_reg(REG_LAYOUT_FLAGS, 16'($urandom_range(0, 127)));
                end
            endcase
            if (phase == 6) calm_phase = 1'b1;
            if (phase == 4) hold_request = 1'b1;
            for (int k = 0; k < 4; k++) begin
                if ($urandom_range(0, 2) == 0) begin
                    it = make_item(ACT_REMOVE, 16'($urandom), 8'($urandom), 8'($urandom),
                                   8'($urandom), 8'($urandom_range(0, 3)));
                    send(it);
                    known_codes.delete();
                end
                for (int g = 0; g < 2; g++)
                    register_glyph(16'($urandom_range(11, 90)), 8'($urandom_range(0, 3)));
                send_string($urandom_range(3, 10));
            end
            // Sender pauses until every expected result has come.
            finish_send();
            settle();
        end

        // One long newline-only string that forces row overflow: its 130 newlines
        // go beyond the row limit.
        write_reg(REG_LAYOUT_FLAGS, 16'h0000);
        for (int i = 0; i < 130; i++) send(glyph_char(NEWLINE_CODE));
        send(make_item(ACT_END, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        finish_send();
        settle();

        if (fail_count == 0) begin
            $display("PASS glyph_text_layout_engine");
        end else begin
            $display("FAIL glyph_text_layout_engine");
        end
        $finish;
    end

endmodule
